// File: hdl/psrlf_pkg.sv
// Package for the per-source rate-limited forwarder.
// Holds field widths, register map, reset values and the controller/datapath
// command and status structs. No dependencies.
package psrlf_pkg;

    // Default number of source-address table entries
    localparam int TABLE_DEPTH_DEF = 16;

    // Item field widths
    localparam int ADDR_W = 48;
    localparam int STR_W  = 8;
    localparam int TIME_W = 32;
    localparam int DATA_W = ADDR_W + STR_W + TIME_W;

    // Request kinds carried in s_tuser
    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Configuration port
    localparam int                  APB_ADDR_W           = 2;
    localparam int                  APB_DATA_W           = 32;
    localparam logic [APB_ADDR_W-1:0] REG_MIN_INTERVAL_ADDR = 2'b00;
    localparam logic [TIME_W-1:0]   MIN_INTERVAL_RST     = 32'd1000;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // capture the accepted input item
        logic clr_flags;  // mark every last-sent time as zero
        logic idx_clr;    // restart the table scan
        logic idx_inc;    // step the scan to the next entry
        logic rd_en;      // read the table at the scan index
        logic save_hit;   // take the matched entry as the slot
        logic append;     // append the address as a new entry
        logic fwd;        // update last-sent time and load the output
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_clear;  // offered input item is a clear request
        logic used_zero;  // table holds no entries
        logic table_full; // table holds TABLE_DEPTH entries
        logic match;      // entry read back holds the item's address
        logic last_idx;   // scan index is the last used entry
        logic pass;       // interval since last forward is long enough
        logic out_busy;   // output register holds an item not taken now
    } status_t;

endpackage

// File: hdl/psrlf_ctrl.sv
// Controller state machine for the per-source rate-limited forwarder.
// Sequences accept, table scan, append and forward decision.
// Depends on psrlf_pkg.
module psrlf_ctrl
    import psrlf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMP,
        ST_MISS,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg;
    logic   accept;

    assign accept   = s_tvalid && tready_reg;
    assign s_tready = tready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch = 1'b1;
                    if (status.req_clear) begin
                        cmd.clr_flags = 1'b1;
                    end else if (status.used_zero) begin
                        state_next = ST_MISS;
                    end else begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                if (status.match) begin
                    cmd.save_hit = 1'b1;
                    state_next   = ST_DECIDE;
                end else if (status.last_idx) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_MISS: begin
                // drop the report when no entry is left
                if (status.table_full) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.append = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!status.pass) begin
                    state_next = ST_IDLE;
                end else if (!status.out_busy) begin
                    cmd.fwd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tready_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            tready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// File: hdl/psrlf_datapath.sv
// Datapath for the per-source rate-limited forwarder: item registers, address
// and last-sent memories, scan counter, fill count and output register.
// Depends on psrlf_pkg.
module psrlf_datapath
    import psrlf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    input  logic [TIME_W-1:0] min_interval,
    input  cmd_t              cmd,
    output status_t           status
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Latched input item
    logic [ADDR_W-1:0]       addr_reg;
    logic signed [STR_W-1:0] str_reg;
    logic [TIME_W-1:0]       now_reg;

    // Table memories and last-sent valid flags
    logic [ADDR_W-1:0]      addr_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]      time_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] flags_reg, flags_next;
    logic [ADDR_W-1:0]      addr_rd_reg;
    logic [TIME_W-1:0]      time_rd_reg;
    logic                   flag_rd_reg;

    // Scan and slot control
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  used_idx;
    logic [IDX_W-1:0]  slot_reg;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] elapsed;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]       out_addr_reg;
    logic signed [STR_W-1:0] out_str_reg;
    logic [TIME_W-1:0]       out_time_reg;

    assign used_idx = used_reg[IDX_W-1:0];
    assign elapsed  = now_reg - last_reg;

    // Status back to the controller
    assign status.req_clear  = (s_tuser == REQ_CLEAR);
    assign status.used_zero  = (used_reg == '0);
    assign status.table_full = (used_reg == CNT_W'(TABLE_DEPTH));
    assign status.match      = (addr_rd_reg == addr_reg);
    assign status.last_idx   = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign status.pass       = (elapsed >= min_interval);
    assign status.out_busy   = out_valid_reg && !m_tready;

    // Next values of control registers
    always_comb begin
        idx_next       = idx_reg;
        used_next      = used_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.clr_flags) begin
            flags_next = '0;
        end
        if (cmd.append) begin
            used_next            = used_reg + CNT_W'(1);
            flags_next[used_idx] = 1'b0;
        end
        if (cmd.fwd) begin
            flags_next[slot_reg] = 1'b1;
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.fwd) begin
            out_valid_next = 1'b1;
        end
    end

    // Hold control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            used_reg      <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input item, the chosen slot and its last-sent time
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            addr_reg <= s_tdata[ADDR_W-1:0];
            str_reg  <= s_tdata[ADDR_W +: STR_W];
            now_reg  <= s_tdata[ADDR_W+STR_W +: TIME_W];
        end
        if (cmd.save_hit) begin
            slot_reg <= idx_reg;
            last_reg <= flag_rd_reg ? time_rd_reg : '0;
        end else if (cmd.append) begin
            slot_reg <= used_idx;
            last_reg <= '0;
        end
    end

    // Address memory: append writes, scan reads
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            addr_mem[used_idx] <= addr_reg;
        end
        if (cmd.rd_en) begin
            addr_rd_reg <= addr_mem[idx_reg];
        end
    end

    // Last-sent memory: forward writes, scan reads
    always_ff @(posedge aclk) begin
        if (cmd.fwd) begin
            time_mem[slot_reg] <= now_reg;
        end
        if (cmd.rd_en) begin
            time_rd_reg <= time_mem[idx_reg];
            flag_rd_reg <= flags_reg[idx_reg];
        end
    end

    // Load the output register on forward
    always_ff @(posedge aclk) begin
        if (cmd.fwd) begin
            out_addr_reg <= addr_reg;
            out_str_reg  <= str_reg;
            out_time_reg <= now_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_time_reg, out_str_reg, out_addr_reg};

endmodule

// File: hdl/per_source_rate_limited_forwarder.sv
// Top level of the per-source rate-limited forwarder: configuration register
// port, controller and datapath. Depends on psrlf_pkg, psrlf_ctrl and
// psrlf_datapath.
//
//  Port group  Direction  Fields (lowest bit first)
//  s_*         in         tuser: req_type; tdata: source_addr, signal_strength, now_ms
//  m_*         out        tdata: fwd_addr, fwd_strength, fwd_time
//  p*          config     min_interval_ms at byte address 0
//
// One item at a time. A clear request is handled in the idle state. A report scans the
// table from entry 0 until its address matches; an unknown address is appended, or the
// report is dropped when the table is full; each table entry costs one memory read and
// one compare.
// Reset is synchronous on aresetn low and empties the table.
// A forward waits while the output register still holds an untaken item;
// the output register frees s_tready once the previous result is waiting.
module per_source_rate_limited_forwarder
    import psrlf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,  // [47:0] source_addr, [55:48] signal_strength,
                                            // [87:56] now_ms
    input  logic                  s_tuser,  // [0] req_type
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,  // [47:0] fwd_addr, [55:48] fwd_strength,
                                            // [87:56] fwd_time
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TIME_W-1:0] min_interval_reg;
    logic              cfg_write;
    cmd_t              cmd;
    status_t           status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Hold the interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= MIN_INTERVAL_RST;
        end else if (cfg_write && (paddr == REG_MIN_INTERVAL_ADDR)) begin
            min_interval_reg <= pwdata[TIME_W-1:0];
        end
    end

    // Read back
    assign prdata = (paddr == REG_MIN_INTERVAL_ADDR) ? APB_DATA_W'(min_interval_reg) : '0;

    psrlf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psrlf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .min_interval (min_interval_reg),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// File: sim/per_source_rate_limited_forwarder_test.sv
// Self-checking bench for the per-source rate-limited forwarder: a directed table
// followed by random report streams, each checked against an in-bench predictor.
// Depends on psrlf_pkg and per_source_rate_limited_forwarder.
module per_source_rate_limited_forwarder_test
    import psrlf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;  // longest scan plus margin
    localparam int HOLD_AT      = 50;               // result count that starts the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 104;
    localparam int MAX_REPORTS  = 200;

    // Item layout: source_addr in the lowest bits, then strength, then time
    typedef struct packed {
        logic [TIME_W-1:0]        now;
        logic signed [STR_W-1:0]  strength;
        logic [ADDR_W-1:0]        addr;
    } report_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {OUT_PREDICT, OUT_DROP, OUT_FWD} outcome_t;

    // One directed step; for a configuration row, now carries the interval
    typedef struct {
        row_kind_t         kind;
        logic              req;
        logic [ADDR_W-1:0] addr;
        logic [STR_W-1:0]  strength;
        logic [TIME_W-1:0] now;
        int                reps;
        outcome_t          outcome;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 15;

    // Interval starts at its reset value of 1000 ms
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'h80, 32'd0,          1,  OUT_DROP},
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'h7f, 32'd1000,       1,  OUT_FWD},
        '{ROW_ITEM, REQ_REPORT, 48'hffff_ffff_ffff, 8'h7f, 32'hffff_ffff, 1,  OUT_FWD},
        // wraps past zero: 999 - 0xffffffff is exactly 1000
        '{ROW_ITEM, REQ_REPORT, 48'hffff_ffff_ffff, 8'h01, 32'd999,      1,  OUT_FWD},
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'h05, 32'd1999,       1,  OUT_DROP},
        '{ROW_ITEM, REQ_CLEAR,  48'hffff_ffff_ffff, 8'hff, 32'hffff_ffff, 1,  OUT_DROP},
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'hfa, 32'd1000,       1,  OUT_FWD},
        '{ROW_CFG,  REQ_REPORT, 48'h0,            8'h00, 32'd0,          1,  OUT_PREDICT},
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'h00, 32'd1000,       1,  OUT_FWD},
        // fill the remaining fourteen entries
        '{ROW_ITEM, REQ_REPORT, 48'h1,            8'h55, 32'd0,          14, OUT_FWD},
        // table full, unknown address
        '{ROW_ITEM, REQ_REPORT, 48'haaaa_aaaa_aaaa, 8'haa, 32'd5,        1,  OUT_DROP},
        '{ROW_ITEM, REQ_REPORT, 48'he,            8'hc3, 32'd77,         1,  OUT_FWD},
        '{ROW_CFG,  REQ_REPORT, 48'h0,            8'h00, 32'hffff_ffff,  1,  OUT_PREDICT},
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'h11, 32'd1000,       1,  OUT_DROP},
        '{ROW_ITEM, REQ_REPORT, 48'h0,            8'h22, 32'd999,        1,  OUT_FWD}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;  // [47:0] source_addr, [55:48] signal_strength,
                                           // [87:56] now_ms
    logic                  s_tuser  = REQ_REPORT;  // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;  // [47:0] fwd_addr, [55:48] fwd_strength,
                                     // [87:56] fwd_time
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic [ADDR_W-1:0] known_addr [DEPTH];
    logic [TIME_W-1:0] last_fwd   [DEPTH];
    int unsigned       known_count = 0;
    logic [TIME_W-1:0] interval_ms = MIN_INTERVAL_RST;

    report_t     pending_forwards [$];
    int unsigned forwards_seen = 0;
    int unsigned errors        = 0;
    bit          gaps_on       = 1'b1;

    per_source_rate_limited_forwarder #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Update the table for one accepted item; return 1 when it is forwarded
    function automatic bit admit_report(input logic req, input report_t rep);
        int                slot;
        logic [TIME_W-1:0] elapsed;
        if (req == REQ_CLEAR) begin
            for (int k = 0; k < known_count; k++) last_fwd[k] = '0;
            return 1'b0;
        end
        slot = -1;
        for (int k = 0; k < known_count; k++) begin
            if (known_addr[k] == rep.addr) begin
                slot = k;
                break;
            end
        end
        if (slot < 0) begin
            if (known_count >= DEPTH) return 1'b0;
            slot = known_count;
            known_count++;
            known_addr[slot] = rep.addr;
            last_fwd[slot]   = '0;
        end
        elapsed = rep.now - last_fwd[slot];
        if (elapsed < interval_ms) return 1'b0;
        last_fwd[slot] = rep.now;
        return 1'b1;
    endfunction

    function automatic void flag_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic offer_item(input logic req, input report_t rep, input outcome_t outcome);
        int unsigned gap;
        bit          fwd;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= rep;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fwd = admit_report(req, rep);
        if (outcome == OUT_FWD || (outcome == OUT_PREDICT && fwd))
            pending_forwards.push_back(rep);
    endtask

    // Stop offering, wait for every forward, then let any last scan finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_forwards.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the interval register, then read it back
    task automatic program_interval(input logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MIN_INTERVAL_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== value)
            flag_field("min_interval_ms readback", 64'(value), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        interval_ms = value;
    endtask

    // Result side: random stalls, one long hold, field-by-field check
    initial begin
        report_t     want;
        report_t     got;
        int unsigned gap;
        bit          held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (!held && forwards_seen == HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = report_t'(m_tdata);
            forwards_seen++;
            if (pending_forwards.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected item, expected none, got %h", $time, got);
            end else begin
                want = pending_forwards.pop_front();
                if (got.addr !== want.addr)
                    flag_field("fwd_addr", 64'(want.addr), 64'(got.addr));
                if (got.strength !== want.strength)
                    flag_field("fwd_strength", {56'd0, want.strength},
                               {56'd0, got.strength});
                if (got.now !== want.now)
                    flag_field("fwd_time", 64'(want.now), 64'(got.now));
            end
        end
    end

    // Stimulus
    initial begin
        report_t           rep;
        logic              req;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] phase_interval;
        int unsigned       pick;
        int unsigned       counted;
        bit                known;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle();
                program_interval(directed_rows[r].now);
            end else begin
                for (int i = 0; i < directed_rows[r].reps; i++) begin
                    rep.addr     = directed_rows[r].addr + ADDR_W'(i);
                    rep.strength = directed_rows[r].strength;
                    rep.now      = directed_rows[r].now;
                    offer_item(directed_rows[r].req, rep, directed_rows[r].outcome);
                end
            end
        end

        // Random phases, each under its own interval
        clock_ms = $urandom();
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_interval = '0;
                1:       phase_interval = 32'd1000;
                2:       phase_interval = 32'd1;
                3:       phase_interval = '1;
                4:       phase_interval = $urandom_range(1, 3000);
                default: phase_interval = $urandom();
            endcase
            settle();
            gaps_on = (p != 2);
            program_interval(phase_interval);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                req   = ($urandom_range(0, 99) < 3) ? REQ_CLEAR : REQ_REPORT;
                known = (known_count != 0) && ($urandom_range(0, 99) < 85);
                pick  = known ? $urandom_range(0, known_count - 1) : 0;
                rep.addr     = known ? known_addr[pick]
                                     : {16'($urandom()), 32'($urandom())};
                rep.strength = 8'($urandom());
                // advance the clock, sit on the interval boundary, or jump anywhere
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        clock_ms += $urandom_range(0, 1500);
                        rep.now = clock_ms;
                    end
                    4, 5, 6: begin
                        rep.now = known ? last_fwd[pick] + interval_ms
                                          - 32'($urandom_range(0, 1))
                                        : clock_ms;
                    end
                    7:       rep.now = $urandom();
                    default: begin
                        clock_ms += $urandom_range(0, 20);
                        rep.now = clock_ms;
                    end
                endcase
                offer_item(req, rep, OUT_PREDICT);
                counted++;
            end
        end

        settle();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Timeout
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
